// ===== src/assert_macros.svh =====
// Assertion macros for the texel store RTL.
// Used by the top level; depends on a clock named clk and a reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define AST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/wbts_pkg.sv =====
// Shared types and constants of the wrapped bilinear texel store.
// No dependencies.
package wbts_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_FILL   = 2'd3
  } action_e;

  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HAS_ALPHA  = 2'd2;

  localparam logic [6:0] TEX_WIDTH_RST  = 7'd64;
  localparam logic [6:0] TEX_HEIGHT_RST = 7'd64;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_TAP_RD,
    ST_TAP_ACC,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       div_step;
    logic       fix;
    logic       acc_clr;
    logic       mem_rd;
    logic       mem_wr;
    logic       acc_en;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       fill_wr;
    logic       clear_wr;
    logic       load_out;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    clear_last;
    logic    fill_last;
  } status_t;

endpackage

// ===== src/wbts_ctrl.sv =====
// Controller state machine of the texel store: sequences clearing, remainder steps,
// texel taps, fill sweep and the result register. Depends on wbts_pkg.
module wbts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  wbts_pkg::status_t stat,
  output wbts_pkg::cmd_t  cmd,
  output logic            busy
);
  import wbts_pkg::*;

  state_e     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] tap_r, tap_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tap_nxt       = tap_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.tap       = tap_r;
    in_stall      = 1'b1;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix     = 1'b1;
        cmd.acc_clr = 1'b1;
        tap_nxt     = '0;
        if (stat.action == ACT_FILL) begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = ST_FILL;
        end else begin
          state_nxt = ST_TAP_RD;
        end
      end
      ST_TAP_RD: begin
        if (stat.action == ACT_WRITE) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_TAP_ACC;
        end
      end
      ST_TAP_ACC: begin
        cmd.acc_en = 1'b1;
        if (stat.action == ACT_READ || tap_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          tap_nxt   = tap_r + 2'd1;
          state_nxt = ST_TAP_RD;
        end
      end
      ST_FILL: begin
        cmd.fill_wr   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign busy      = (state_r != ST_IDLE);

endmodule

// ===== src/wbts_dp.sv =====
// Datapath of the texel store: texel memory, remainder unit, weights, accumulators
// and result register. Depends on wbts_pkg; driven by wbts_ctrl.
module wbts_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wbts_pkg::in_item_t in_item,
  input  logic [6:0]         width,
  input  logic [6:0]         height,
  input  logic               has_alpha,
  input  wbts_pkg::cmd_t     cmd,
  output wbts_pkg::status_t  stat,
  output wbts_pkg::out_item_t out_item
);
  import wbts_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW > 14) ? AW : 14;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  action_e     action_r;
  logic [31:0] colour_r;
  logic [7:0]  fx_r, fy_r;
  logic [7:0]  xm_r, ym_r;
  logic        xneg_r, yneg_r;
  logic [7:0]  xrem_r, yrem_r;
  logic [6:0]  x0_r, x1_r, y0_r, y1_r;
  logic [16:0] w_r [4];
  logic [24:0] acc_r [4];
  logic [AW-1:0] sweep_r;
  out_item_t   out_r;

  logic signed [7:0] xi, yi;
  logic [7:0]  xt, yt;
  logic [6:0]  x0_c, y0_c;
  logic [8:0]  wx0, wx1, wy0, wy1;
  logic [17:0] p00, p10, p01, p11;
  logic [6:0]  ax, ay;
  logic [AW-1:0] tap_addr, addr;
  logic [3:0]  be;
  logic [31:0] wdata;
  logic [31:0] tex;
  logic [16:0] wsel;
  logic [31:0] res;

  assign xi = in_item.x_coord[15:8];
  assign yi = in_item.y_coord[15:8];
  assign xt = {xrem_r[6:0], xm_r[7]};
  assign yt = {yrem_r[6:0], ym_r[7]};

  always_comb begin
    x0_c = (xneg_r && xrem_r != 8'd0) ? (width - xrem_r[6:0]) : xrem_r[6:0];
    y0_c = (yneg_r && yrem_r != 8'd0) ? (height - yrem_r[6:0]) : yrem_r[6:0];
    wx1  = {1'b0, fx_r};
    wy1  = {1'b0, fy_r};
    wx0  = 9'd256 - wx1;
    wy0  = 9'd256 - wy1;
    p00  = wx0 * wy0;
    p10  = wx1 * wy0;
    p01  = wx0 * wy1;
    p11  = wx1 * wy1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= action_e'(in_item.action);
      colour_r <= {in_item.alpha_in, in_item.blue_in, in_item.green_in, in_item.red_in};
      fx_r     <= in_item.x_coord[7:0];
      fy_r     <= in_item.y_coord[7:0];
      xneg_r   <= xi[7];
      yneg_r   <= yi[7];
      xm_r     <= xi[7] ? 8'(-xi) : 8'(xi);
      ym_r     <= yi[7] ? 8'(-yi) : 8'(yi);
      xrem_r   <= '0;
      yrem_r   <= '0;
    end
    if (cmd.div_step) begin
      xm_r   <= {xm_r[6:0], 1'b0};
      ym_r   <= {ym_r[6:0], 1'b0};
      xrem_r <= (xt >= {1'b0, width}) ? (xt - {1'b0, width}) : xt;
      yrem_r <= (yt >= {1'b0, height}) ? (yt - {1'b0, height}) : yt;
    end
    if (cmd.fix) begin
      x0_r   <= x0_c;
      y0_r   <= y0_c;
      x1_r   <= (x0_c + 7'd1 == width) ? 7'd0 : x0_c + 7'd1;
      y1_r   <= (y0_c + 7'd1 == height) ? 7'd0 : y0_c + 7'd1;
      w_r[0] <= p00[16:0];
      w_r[1] <= p10[16:0];
      w_r[2] <= p01[16:0];
      w_r[3] <= p11[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_r <= sweep_r + AW'(1);
    end
  end

  assign ax       = cmd.tap[0] ? x1_r : x0_r;
  assign ay       = cmd.tap[1] ? y1_r : y0_r;
  assign tap_addr = AW'(ay) * AW'(width) + AW'(ax);
  assign addr     = (cmd.clear_wr || cmd.fill_wr) ? sweep_r : tap_addr;

  always_comb begin
    if (cmd.clear_wr) begin
      be    = 4'b1111;
      wdata = '0;
    end else begin
      be    = {has_alpha & (cmd.fill_wr | cmd.mem_wr), {3{cmd.fill_wr | cmd.mem_wr}}};
      wdata = colour_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (be[b]) begin
        mem[addr][b*8 +: 8] <= wdata[b*8 +: 8];
      end
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign tex  = has_alpha ? rdata_r : (rdata_r | 32'hFF00_0000);
  assign wsel = w_r[cmd.tap];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (cmd.acc_clr) begin
        acc_r[c] <= '0;
      end else if (cmd.acc_en) begin
        acc_r[c] <= acc_r[c] + {17'd0, tex[c*8 +: 8]} * {8'd0, wsel};
      end
    end
  end

  always_comb begin
    case (action_r)
      ACT_READ: begin
        res = tex;
      end
      ACT_SAMPLE: begin
        for (int c = 0; c < 4; c++) begin
          res[c*8 +: 8] = 8'((acc_r[c] + 25'd32768) >> 16);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= '{red_out: res[7:0], green_out: res[15:8],
                 blue_out: res[23:16], alpha_out: res[31:24]};
    end
  end

  assign out_item        = out_r;
  assign stat.action     = action_r;
  assign stat.clear_last = (sweep_r == AW'(DEPTH - 1));
  assign stat.fill_last  = (CW'(sweep_r) + CW'(1) == CW'(width) * CW'(height));

endmodule

// ===== src/wrapped_bilinear_texel_store.sv =====
// Top level of the wrapped bilinear texel store: configuration registers and glue.
// Depends on wbts_pkg, wbts_ctrl, wbts_dp and assert_macros.svh.
//
// After reset the block clears its MAX_WIDTH*MAX_HEIGHT texel words, one per cycle,
// and accepts no item during that pass. Each item then runs through an 8-step
// remainder unit that wraps both coordinates, and through the single-port texel
// memory, one access per texel: a write makes one write, a read one read, a
// bilinear sample four reads, each followed by an accumulate, and a fill one
// write to each of width*height words. Items are processed one at a time; the
// result register lets the next item enter while a result still waits to be taken.
`include "assert_macros.svh"

module wrapped_bilinear_texel_store #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output wbts_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wbts_pkg::*;

  logic [6:0] tex_width_r, tex_height_r;
  logic       has_alpha_r;
  logic [6:0] width_eff, height_eff;
  logic       cfg_wr;
  cmd_t       cmd;
  status_t    stat;
  logic       busy;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= TEX_WIDTH_RST;
      tex_height_r <= TEX_HEIGHT_RST;
      has_alpha_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TEX_WIDTH:  tex_width_r  <= pwdata[6:0];
        REG_TEX_HEIGHT: tex_height_r <= pwdata[6:0];
        REG_HAS_ALPHA:  has_alpha_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEX_WIDTH:  prdata = {25'd0, tex_width_r};
      REG_TEX_HEIGHT: prdata = {25'd0, tex_height_r};
      REG_HAS_ALPHA:  prdata = {31'd0, has_alpha_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (tex_width_r == 7'd0) begin
      width_eff = 7'd1;
    end else if (int'(tex_width_r) > MAX_WIDTH) begin
      width_eff = 7'(MAX_WIDTH);
    end else begin
      width_eff = tex_width_r;
    end
    if (tex_height_r == 7'd0) begin
      height_eff = 7'd1;
    end else if (int'(tex_height_r) > MAX_HEIGHT) begin
      height_eff = 7'(MAX_HEIGHT);
    end else begin
      height_eff = tex_height_r;
    end
  end

  wbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  wbts_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .width     (width_eff),
    .height    (height_eff),
    .has_alpha (has_alpha_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

  `AST_CLK(a_accept_busy, (in_valid && !in_stall) |=> busy, "accepted item did not start work")
  `AST_CLK(a_result_from_work, $rose(out_valid) |-> $past(busy), "result without work")
  `AST_NEVER(a_load_while_held, cmd.load_out && out_valid && out_stall, "result overwritten")

endmodule

// ===== tb/tb_wrapped_bilinear_texel_store.sv =====
// Testbench for the wrapped bilinear texel store: random and directed items with a scoreboard.
// Depends on wbts_pkg and the wrapped_bilinear_texel_store RTL.
module tb_wrapped_bilinear_texel_store;
  timeunit 1ns;
  timeprecision 1ps;
  import wbts_pkg::*;

  class texel_scoreboard;
    bit [31:0] texels[4096];
    bit [6:0] width_reg = 7'd64;
    bit [6:0] height_reg = 7'd64;
    bit alpha_reg = 1'b1;
    out_item_t pending[$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, bit [31:0] value);
      if (idx == REG_TEX_WIDTH) width_reg = value[6:0];
      else if (idx == REG_TEX_HEIGHT) height_reg = value[6:0];
      else if (idx == REG_HAS_ALPHA) alpha_reg = value[0];
    endfunction

    function int clamp_dim(bit [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return int'(v);
    endfunction

    function int wrap_pos(int v, int n);
      int r;
      r = v % n;
      if (r < 0) r += n;
      return r;
    endfunction

    function bit [31:0] texel_at(int x, int y, int w, int h);
      bit [31:0] t;
      t = texels[wrap_pos(y, h) * w + wrap_pos(x, w)];
      if (!alpha_reg) t[31:24] = 8'hFF;
      return t;
    endfunction

    function void note_item(in_item_t it);
      int w, h, xi, yi, addr;
      int unsigned fx, fy, s;
      bit [31:0] colour, keep, res, c00, c10, c01, c11;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      keep = alpha_reg ? 32'h0 : 32'hFF00_0000;
      colour = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
      xi = int'(it.x_coord) >>> 8;
      yi = int'(it.y_coord) >>> 8;
      fx = 32'(it.x_coord[7:0]);
      fy = 32'(it.y_coord[7:0]);
      res = '0;
      case (action_e'(it.action))
        ACT_WRITE: begin
          addr = wrap_pos(yi, h) * w + wrap_pos(xi, w);
          texels[addr] = (texels[addr] & keep) | (colour & ~keep);
        end
        ACT_FILL: begin
          for (int i = 0; i < w * h; i++) texels[i] = (texels[i] & keep) | (colour & ~keep);
        end
        ACT_READ: res = texel_at(xi, yi, w, h);
        default: begin
          c00 = texel_at(xi, yi, w, h);
          c10 = texel_at(xi + 1, yi, w, h);
          c01 = texel_at(xi, yi + 1, w, h);
          c11 = texel_at(xi + 1, yi + 1, w, h);
          for (int ch = 0; ch < 4; ch++) begin
            s = c00[ch*8 +: 8] * (256 - fx) * (256 - fy) + c10[ch*8 +: 8] * fx * (256 - fy)
              + c01[ch*8 +: 8] * (256 - fx) * fy + c11[ch*8 +: 8] * fx * fy;
            res[ch*8 +: 8] = 8'((s + 32768) >> 16);
          end
        end
      endcase
      pending.push_back('{red_out: res[7:0], green_out: res[15:8],
                          blue_out: res[23:16], alpha_out: res[31:24]});
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red_out !== want.red_out)
        $display("%0t: red expected %h actual %h", $time, want.red_out, got.red_out);
      if (got.green_out !== want.green_out)
        $display("%0t: green expected %h actual %h", $time, want.green_out, got.green_out);
      if (got.blue_out !== want.blue_out)
        $display("%0t: blue expected %h actual %h", $time, want.blue_out, got.blue_out);
      if (got.alpha_out !== want.alpha_out)
        $display("%0t: alpha expected %h actual %h", $time, want.alpha_out, got.alpha_out);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1;
  in_item_t in_item = '0;
  out_item_t out_item;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  texel_scoreboard board = new();
  bit sender_done = 0, timed_out = 0, hold_request = 0;
  int idle_cycles = 0;

  wrapped_bilinear_texel_store uut (.*);

  initial forever #6 clk = ~clk;

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic write_reg(logic [1:0] idx, bit [31:0] value);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_reg(idx, value);
  endtask

  task automatic send_item(in_item_t it);
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
    in_valid <= 0;
    repeat (gap_len() + 1) @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  function in_item_t random_item(int w, int h);
    in_item_t it;
    it = in_item_t'(66'({$urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0, 1, 2: it.action = ACT_WRITE;
      3, 4: it.action = ACT_READ;
      5, 6, 7, 8: it.action = ACT_SAMPLE;
      default: it.action = ($urandom_range(0, 3) == 0) ? ACT_FILL : ACT_SAMPLE;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      it.x_coord = 16'($signed($urandom_range(0, 3 * w * 256)) - w * 256);
      it.y_coord = 16'($signed($urandom_range(0, 3 * h * 256)) - h * 256);
    end
    return it;
  endfunction

  task automatic run_phase(bit [6:0] w, bit [6:0] h, bit a, int count);
    int ew, eh;
    write_reg(REG_TEX_WIDTH, 32'(w));
    write_reg(REG_TEX_HEIGHT, 32'(h));
    write_reg(REG_HAS_ALPHA, 32'(a));
    ew = board.clamp_dim(w);
    eh = board.clamp_dim(h);
    for (int i = 0; i < count; i++) send_item(random_item(ew, eh));
    drain();
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    write_reg(REG_TEX_WIDTH, 4);
    write_reg(REG_TEX_HEIGHT, 3);
    it = '0;
    it.action = ACT_READ; send_item(it);
    it.action = ACT_WRITE; it.red_in = 8'hFF; it.green_in = 8'h80; it.blue_in = 8'h01;
    it.alpha_in = 8'hFF; send_item(it);
    it.x_coord = 16'sh0380; it.y_coord = 16'sh0240; it.red_in = 8'h00; it.alpha_in = 8'h7F;
    send_item(it);
    it.x_coord = -16'sd1; it.y_coord = -16'sd32768; send_item(it);
    it.x_coord = 16'sh7FFF; it.y_coord = 16'sh7FFF; it.red_in = 8'hAA; send_item(it);
    it.action = ACT_SAMPLE; it.x_coord = 16'sh0380; it.y_coord = 16'sh0240; send_item(it);
    it.x_coord = -16'sd1; it.y_coord = -16'sd129; send_item(it);
    it.x_coord = -16'sd32768; it.y_coord = 16'sh7FFF; send_item(it);
    it.action = ACT_READ; it.x_coord = -16'sd256; it.y_coord = -16'sd256; send_item(it);
    drain();
    write_reg(REG_HAS_ALPHA, 0);
    it.action = ACT_WRITE; it.x_coord = 0; it.y_coord = 0; it.alpha_in = 8'h11;
    send_item(it);
    it.action = ACT_READ; send_item(it);
    it.action = ACT_FILL; it.red_in = 8'h55; send_item(it);
    it.action = ACT_SAMPLE; it.x_coord = 16'sh0080; send_item(it);
    drain();
    write_reg(REG_HAS_ALPHA, 1);
    it.action = ACT_READ; send_item(it);
    drain();
    write_reg(REG_TEX_WIDTH, 0);
    write_reg(REG_TEX_HEIGHT, 32'h7F);
    it.action = ACT_SAMPLE; it.x_coord = 16'sh0140; it.y_coord = 16'sh3F80; send_item(it);
    it.action = ACT_FILL; it.alpha_in = 8'hC3; send_item(it);
    it.action = ACT_READ; it.y_coord = 16'sh0500; send_item(it);
    drain();
    hold_request = 1;
    run_phase(2, 2, 1, 200);
    run_phase(1, 1, 0, 100);
    run_phase(5, 7, 1, 250);
    run_phase(64, 64, 1, 200);
    run_phase(3, 64, 0, 150);
    run_phase(0, 9, 1, 100);
    run_phase(127, 2, 0, 130);
    sender_done = 1;
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int g;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1;
        repeat (300) @(posedge clk);
      end
      g = gap_len();
      out_stall <= (g != 0);
      repeat (g != 0 ? g : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/wbts_pkg.sv
src/wbts_ctrl.sv
src/wbts_dp.sv
src/wrapped_bilinear_texel_store.sv
tb/tb_wrapped_bilinear_texel_store.sv
